/* design/lrd_pkg.sv */
// Shared types, constants and a helper function for the logger record deframer.
package lrd_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 24;
    localparam int LOW_W    = 16;
    localparam int CHAN_W   = 3;
    localparam int MASK_W   = 5;
    localparam int SPB_W    = 16;
    localparam int CNT_W    = 32;
    localparam int SAMPLE_W = 33;
    localparam int HDR_W    = 8;
    localparam int BIW_W    = 2;
    localparam int IDX_W    = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_SAMPLES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK      = 2'd3;

    // Byte position inside a 24-bit word
    localparam logic [BIW_W-1:0] BIW_LOW  = 2'd0;
    localparam logic [BIW_W-1:0] BIW_MID  = 2'd1;

    localparam logic [SPB_W-1:0]    RST_SAMPLES_PER_BLOCK = 16'd32;
    localparam logic [CNT_W-1:0]    RST_SKIP_SAMPLES      = 32'd0;
    localparam logic [CNT_W-1:0]    RST_WINDOW_SAMPLES    = 32'd1;
    localparam logic [MASK_W-1:0]   RST_CHANNEL_MASK      = 5'h1F;
    localparam logic [SAMPLE_W-1:0] RST_WIN_END           = 33'd1;

    // One completed word, handed from the framer to the output stage
    typedef struct packed {
        logic                complete;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
        logic [WORD_W-1:0]   word;
    } t_word_evt;

    typedef struct packed {
        logic              found;
        logic [CHAN_W-1:0] channel;
    } t_top_chan;

    // Highest enabled channel in the mask
    function automatic t_top_chan top_channel(input logic [MASK_W-1:0] mask);
        t_top_chan res;
        res.found   = 1'b0;
        res.channel = '0;
        for (int c = 0; c < MASK_W; c++) begin
            if (mask[c]) begin
                res.found   = 1'b1;
                res.channel = CHAN_W'(c);
            end
        end
        return res;
    endfunction

endpackage

/* design/lrd_frame.sv */
// Block framing: header drop, byte assembly and channel / sample counters.
module lrd_frame #(
    parameter int HEADER_BYTES = 32,
    parameter int NUM_CHANNELS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lrd_pkg::BYTE_W-1:0]    i_byte,
    input  logic [lrd_pkg::SPB_W-1:0]     i_samples_per_block,
    input  logic [lrd_pkg::SAMPLE_W-1:0]  i_win_end,
    output lrd_pkg::t_word_evt            o_evt
);

    localparam logic [lrd_pkg::HDR_W-1:0]  HDR_LEN  = lrd_pkg::HDR_W'(HEADER_BYTES);
    localparam logic [lrd_pkg::CHAN_W-1:0] CH_LAST  = lrd_pkg::CHAN_W'(NUM_CHANNELS - 1);

    logic                          r_in_header;
    logic [lrd_pkg::HDR_W-1:0]     r_hdr_cnt;
    logic [lrd_pkg::BIW_W-1:0]     r_biw;
    logic [lrd_pkg::CHAN_W-1:0]    r_chan;
    logic [lrd_pkg::SPB_W-1:0]     r_sib;
    logic [lrd_pkg::SAMPLE_W-1:0]  r_gs;
    logic [lrd_pkg::LOW_W-1:0]     r_low;
    logic                          r_finished;

    logic                          hdr_active;
    logic                          live;
    logic                          word_done;
    logic [lrd_pkg::HDR_W-1:0]     n_hdr_cnt;
    logic [lrd_pkg::SAMPLE_W-1:0]  n_gs;
    logic [lrd_pkg::SPB_W-1:0]     n_sib;

    assign hdr_active = r_in_header && (r_hdr_cnt < HDR_LEN);
    assign live       = i_accept && !r_finished;
    assign word_done  = live && !hdr_active &&
                        (r_biw != lrd_pkg::BIW_LOW) && (r_biw != lrd_pkg::BIW_MID);
    assign n_hdr_cnt  = r_hdr_cnt + 1'b1;
    assign n_gs       = r_gs + 1'b1;
    assign n_sib      = r_sib + 1'b1;

    assign o_evt.complete = word_done;
    assign o_evt.channel  = r_chan;
    assign o_evt.sample   = r_gs;
    assign o_evt.word     = {i_byte, r_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b1;
            r_hdr_cnt   <= '0;
            r_biw       <= lrd_pkg::BIW_LOW;
            r_chan      <= '0;
            r_sib       <= '0;
            r_gs        <= '0;
            r_low       <= '0;
            r_finished  <= 1'b0;
        end else if (live) begin
            if (hdr_active) begin
                r_hdr_cnt <= n_hdr_cnt;
                if (n_hdr_cnt >= HDR_LEN) begin
                    r_in_header <= 1'b0;
                end
            end else begin
                r_in_header <= 1'b0;
                if (r_biw == lrd_pkg::BIW_LOW) begin
                    r_low[7:0] <= i_byte;
                    r_low[15:8] <= '0;
                    r_biw      <= lrd_pkg::BIW_MID;
                end else if (r_biw == lrd_pkg::BIW_MID) begin
                    r_low[15:8] <= i_byte;
                    r_biw       <= r_biw + 1'b1;
                end else begin
                    r_biw <= lrd_pkg::BIW_LOW;
                    if (r_chan == CH_LAST) begin
                        r_chan <= '0;
                        r_gs   <= n_gs;
                        if (n_gs >= i_win_end) begin
                            r_finished <= 1'b1;
                        end
                        if (n_sib == i_samples_per_block) begin
                            r_sib       <= '0;
                            r_in_header <= 1'b1;
                            r_hdr_cnt   <= '0;
                        end else begin
                            r_sib <= n_sib;
                        end
                    end else begin
                        r_chan <= r_chan + 1'b1;
                    end
                end
            end
        end
    end

endmodule

/* design/lrd_emit.sv */
// Window and mask selection with the registered output word.
module lrd_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrd_pkg::t_word_evt            i_evt,
    input  logic [lrd_pkg::CNT_W-1:0]     i_skip,
    input  logic [lrd_pkg::SAMPLE_W-1:0]  i_win_end,
    input  logic [lrd_pkg::MASK_W-1:0]    i_mask,
    input  logic                          i_take,
    output logic                          o_valid,
    output logic [lrd_pkg::WORD_W-1:0]    o_value,
    output logic [lrd_pkg::CHAN_W-1:0]    o_channel,
    output logic [lrd_pkg::IDX_W-1:0]     o_index,
    output logic                          o_last
);

    logic                           r_valid;
    logic [lrd_pkg::WORD_W-1:0]     r_value;
    logic [lrd_pkg::CHAN_W-1:0]     r_channel;
    logic [lrd_pkg::IDX_W-1:0]      r_index;
    logic                           r_last;

    logic                           in_window;
    logic                           enabled;
    logic                           at_end;
    logic                           emit;
    lrd_pkg::t_top_chan             top;
    logic [lrd_pkg::SAMPLE_W:0]     sample_p1;
    logic [lrd_pkg::SAMPLE_W-1:0]   offset;

    assign in_window = (i_evt.sample >= {1'b0, i_skip}) && (i_evt.sample < i_win_end);
    assign enabled   = (i_evt.channel < lrd_pkg::CHAN_W'(lrd_pkg::MASK_W)) &&
                       i_mask[i_evt.channel];
    assign sample_p1 = {1'b0, i_evt.sample} + 1'b1;
    assign at_end    = (sample_p1 == {1'b0, i_win_end});
    assign top       = lrd_pkg::top_channel(i_mask);
    assign offset    = i_evt.sample - {1'b0, i_skip};
    assign emit      = i_evt.complete && in_window && enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: load on a selected word, hold otherwise
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value   <= i_evt.word;
            r_channel <= i_evt.channel;
            r_index   <= offset[lrd_pkg::IDX_W-1:0];
            r_last    <= at_end && top.found && (top.channel == i_evt.channel);
        end
    end

    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_channel = r_channel;
    assign o_index   = r_index;
    assign o_last    = r_last;

endmodule

/* design/logger_record_deframer.sv */
// Top level of the logger record deframer: config registers, framer and output stage.
//
//  channel      | dir | handshake               | payload (lowest bit first)
//  -------------+-----+-------------------------+-------------------------------------
//  s_axis       | in  | tvalid / tready         | tdata[7:0] stream_byte
//  m_axis       | out | tvalid / tready         | tdata sample_value[23:0],
//               |     |                         |   window_index[55:24]; tuser channel_id;
//               |     |                         |   tlast last_word
//  cfg          | in  | we (no wait, no reads)  | idx selects register, wdata[31:0]
//
//  One byte is taken per clock; each byte is decided in the cycle it is accepted
//  and a selected word lands in the output register on that same edge.
//  The input side stalls only while the output register holds an untaken word
//  and the sink is not ready; the readiness path runs straight from i_m_axis_tready.
//  Synchronous active-low reset returns to the start of a block header with the
//  register defaults; the end-of-window latch is cleared only by reset.
module logger_record_deframer #(
    parameter int HEADER_BYTES = 32,
    parameter int NUM_CHANNELS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Byte stream in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] stream_byte
    // Word stream out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [55:0]                     o_m_axis_tdata,   // [23:0] sample_value,
                                                              // [55:24] window_index
    output logic [2:0]                      o_m_axis_tuser,   // [2:0] channel_id
    output logic                            o_m_axis_tlast,   // last_word
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [lrd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lrd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [lrd_pkg::SPB_W-1:0]     r_spb;
    logic [lrd_pkg::CNT_W-1:0]     r_skip;
    logic [lrd_pkg::CNT_W-1:0]     r_window;
    logic [lrd_pkg::MASK_W-1:0]    r_mask;
    // End of the window, kept alongside skip and window so the byte path adds nothing
    logic [lrd_pkg::SAMPLE_W-1:0]  r_win_end;

    logic                          s_ready;
    logic                          s_accept;
    logic                          m_valid;
    logic [lrd_pkg::WORD_W-1:0]    m_value;
    logic [lrd_pkg::IDX_W-1:0]     m_index;
    lrd_pkg::t_word_evt            evt;

    // Config registers; window end follows skip and window writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb     <= lrd_pkg::RST_SAMPLES_PER_BLOCK;
            r_skip    <= lrd_pkg::RST_SKIP_SAMPLES;
            r_window  <= lrd_pkg::RST_WINDOW_SAMPLES;
            r_mask    <= lrd_pkg::RST_CHANNEL_MASK;
            r_win_end <= lrd_pkg::RST_WIN_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lrd_pkg::REG_SAMPLES_PER_BLOCK: begin
                    r_spb <= i_cfg_wdata[lrd_pkg::SPB_W-1:0];
                end
                lrd_pkg::REG_SKIP_SAMPLES: begin
                    r_skip    <= i_cfg_wdata;
                    r_win_end <= {1'b0, i_cfg_wdata} + {1'b0, r_window};
                end
                lrd_pkg::REG_WINDOW_SAMPLES: begin
                    r_window  <= i_cfg_wdata;
                    r_win_end <= {1'b0, r_skip} + {1'b0, i_cfg_wdata};
                end
                lrd_pkg::REG_CHANNEL_MASK: begin
                    r_mask <= i_cfg_wdata[lrd_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Accept whenever the output register is free or being drained this cycle
    assign s_ready  = !m_valid || i_m_axis_tready;
    assign s_accept = i_s_axis_tvalid && s_ready;

    lrd_frame #(
        .HEADER_BYTES (HEADER_BYTES),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_frame (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (s_accept),
        .i_byte              (i_s_axis_tdata),
        .i_samples_per_block (r_spb),
        .i_win_end           (r_win_end),
        .o_evt               (evt)
    );

    lrd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (evt),
        .i_skip    (r_skip),
        .i_win_end (r_win_end),
        .i_mask    (r_mask),
        .i_take    (i_m_axis_tready),
        .o_valid   (m_valid),
        .o_value   (m_value),
        .o_channel (o_m_axis_tuser),
        .o_index   (m_index),
        .o_last    (o_m_axis_tlast)
    );

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = m_valid;
    assign o_m_axis_tdata  = {m_index, m_value};

endmodule

/* verif/logger_record_deframer_checker.sv */
// Checker for the logger record deframer: predicts each output word and compares it.
module logger_record_deframer_checker #(
    parameter int HEADER_BYTES = 32,
    parameter int NUM_CHANNELS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] stream_byte
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [55:0]                     i_m_axis_tdata,   // [23:0] sample_value,
                                                              // [55:24] window_index
    input  logic [2:0]                      i_m_axis_tuser,   // [2:0] channel_id
    input  logic                            i_m_axis_tlast,   // last_word
    input  logic                            i_cfg_we,
    input  logic [lrd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lrd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                              o_mismatches,
    output int                              o_words_due
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [23:0] value;
        logic [2:0]  chan;
        logic [31:0] index;
        logic        last;
    } t_deframed_word;

    t_deframed_word words_due[$];
    int             mismatches;

    // Register copies
    logic [15:0] spb_q;
    logic [31:0] skip_q;
    logic [31:0] win_q;
    logic [4:0]  mask_q;

    // Framing state
    logic        in_hdr;
    logic [7:0]  hdr_cnt;
    logic [1:0]  byte_pos;
    logic [2:0]  chan;
    logic [15:0] blk_smp;
    logic [32:0] smp_cnt;
    logic [15:0] low16;
    logic        done;

    task automatic absorb_byte(input logic [7:0] b);
        logic [32:0]    win_end;
        logic [23:0]    word;
        logic           in_win;
        logic           chan_on;
        logic           top_found;
        logic [2:0]     top_chan;
        t_deframed_word w;
        win_end   = {1'b0, skip_q} + {1'b0, win_q};
        top_found = 1'b0;
        top_chan  = '0;
        if (done) return;
        if (in_hdr && int'(hdr_cnt) < HEADER_BYTES) begin
            hdr_cnt = hdr_cnt + 8'd1;
            if (int'(hdr_cnt) >= HEADER_BYTES) in_hdr = 1'b0;
            return;
        end
        in_hdr = 1'b0;
        if (byte_pos == 2'd0) begin
            low16    = {8'd0, b};
            byte_pos = 2'd1;
            return;
        end
        if (byte_pos == 2'd1) begin
            low16[15:8] = b;
            byte_pos    = 2'd2;
            return;
        end
        // third byte closes the word
        byte_pos = 2'd0;
        word     = {b, low16};
        in_win   = smp_cnt >= {1'b0, skip_q} && smp_cnt < win_end;
        chan_on  = int'(chan) < lrd_pkg::MASK_W && mask_q[chan];
        if (in_win && chan_on) begin
            for (int c = 0; c < lrd_pkg::MASK_W && c < NUM_CHANNELS; c++) begin
                if (mask_q[c]) begin
                    top_found = 1'b1;
                    top_chan  = 3'(c);
                end
            end
            w.value = word;
            w.chan  = chan;
            w.index = 32'(smp_cnt - {1'b0, skip_q});
            w.last  = (smp_cnt + 33'd1 == win_end) && top_found && top_chan == chan;
            words_due = {words_due, w};
        end
        if (int'(chan) + 1 >= NUM_CHANNELS) begin
            chan    = '0;
            smp_cnt = smp_cnt + 33'd1;
            if (smp_cnt >= win_end) done = 1'b1;
            blk_smp = blk_smp + 16'd1;
            if (blk_smp == spb_q) begin
                blk_smp = '0;
                in_hdr  = 1'b1;
                hdr_cnt = '0;
            end
        end else begin
            chan = chan + 3'd1;
        end
    endtask

    task automatic check_word();
        t_deframed_word want;
        t_deframed_word got;
        got.value = i_m_axis_tdata[23:0];
        got.index = i_m_axis_tdata[55:24];
        got.chan  = i_m_axis_tuser;
        got.last  = i_m_axis_tlast;
        if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("checker: unexpected word value %0d channel %0d index %0d last %0b",
                         $signed(got.value), got.chan, got.index, got.last);
            return;
        end
        want = words_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("checker: word mismatch, expected value %0d channel %0d index %0d last %0b",
                         $signed(want.value), want.chan, want.index, want.last);
                $display("checker:                got value %0d channel %0d index %0d last %0b",
                         $signed(got.value), got.chan, got.index, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spb_q    = lrd_pkg::RST_SAMPLES_PER_BLOCK;
            skip_q   = lrd_pkg::RST_SKIP_SAMPLES;
            win_q    = lrd_pkg::RST_WINDOW_SAMPLES;
            mask_q   = lrd_pkg::RST_CHANNEL_MASK;
            in_hdr   = 1'b1;
            hdr_cnt  = '0;
            byte_pos = '0;
            chan     = '0;
            blk_smp  = '0;
            smp_cnt  = '0;
            low16    = '0;
            done     = 1'b0;
            words_due.delete();
            mismatches = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) absorb_byte(i_s_axis_tdata);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lrd_pkg::REG_SAMPLES_PER_BLOCK: spb_q  = i_cfg_wdata[15:0];
                    lrd_pkg::REG_SKIP_SAMPLES:      skip_q = i_cfg_wdata;
                    lrd_pkg::REG_WINDOW_SAMPLES:    win_q  = i_cfg_wdata;
                    lrd_pkg::REG_CHANNEL_MASK:      mask_q = i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) check_word();
        end
        o_mismatches <= mismatches;
        o_words_due  <= words_due.size();
    end

endmodule

/* verif/logger_record_deframer_test.sv */
// Test top for the logger record deframer: drives bytes and register writes, gives the verdict.
module logger_record_deframer_test;

    localparam int HDR_BYTES     = 32;
    localparam int N_CHANNELS    = 5;
    localparam int SAMPLE_BYTES  = 3 * N_CHANNELS;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_BYTES   = 80;
    localparam int TAIL_BYTES    = 20;
    localparam int RUN_LIMIT     = 400000;  // cycles

    typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} t_idle_mode;
    typedef enum {END_LAST_WORD, END_NO_CHANNELS, END_EMPTY_WINDOW} t_end_kind;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [lrd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    int          mismatches;
    int          words_due;

    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          sent_bytes = 0;

    // Stimulus-side view of where the stream stands, used only to shape the next bytes
    int          hdr_left = HDR_BYTES;
    int          smp_byte = 0;
    logic [15:0] blk_fill = '0;
    logic [63:0] smp_sent = '0;
    logic [15:0] spb_now  = lrd_pkg::RST_SAMPLES_PER_BLOCK;
    logic [31:0] skip_now = lrd_pkg::RST_SKIP_SAMPLES;
    logic [31:0] win_now  = lrd_pkg::RST_WINDOW_SAMPLES;
    logic        stream_ended = 1'b0;

    logger_record_deframer #(
        .HEADER_BYTES (HDR_BYTES),
        .NUM_CHANNELS (N_CHANNELS)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    logger_record_deframer_checker #(
        .HEADER_BYTES (HDR_BYTES),
        .NUM_CHANNELS (N_CHANNELS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .o_mismatches    (mismatches),
        .o_words_due     (words_due)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs or words go missing
    initial begin
        #(RUN_LIMIT * 2 * CLK_HALF);
        $display("logger_record_deframer_test: done, errors");
        $finish;
    end

    // Sink back-pressure: redraw tready every cycle
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        src_idle_pct  = (mode == IDLE_SOURCE) ? 84 : (mode == IDLE_BOTH) ? 15 : 0;
        snk_stall_pct = (mode == IDLE_SINK)   ? 84 : (mode == IDLE_BOTH) ? 15 : 0;
    endtask

    // Bias towards sign-boundary and all-ones/all-zeros bytes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the stimulus-side frame position by one accepted byte
    task automatic follow_frame();
        if (stream_ended) return;
        if (hdr_left > 0) begin
            hdr_left--;
            return;
        end
        smp_byte++;
        if (smp_byte == SAMPLE_BYTES) begin
            smp_byte = 0;
            smp_sent++;
            blk_fill = blk_fill + 16'd1;
            if (smp_sent >= {32'd0, skip_now} + {32'd0, win_now}) stream_ended = 1'b1;
            if (blk_fill == spb_now) begin
                blk_fill = '0;
                hdr_left = HDR_BYTES;
            end
        end
    endtask

    // Offer one byte; hold it until the block takes it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent_bytes++;
        follow_frame();
    endtask

    // Finish the current header or sample, or send one whole sample
    task automatic send_unit();
        int n;
        n = (hdr_left > 0) ? hdr_left : SAMPLE_BYTES - smp_byte;
        repeat (n) send_byte(pick_byte());
    endtask

    // Misalign the stream with a short burst of raw bytes
    task automatic send_noise();
        repeat ($urandom_range(1, SAMPLE_BYTES - 1)) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [lrd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] spb, input logic [31:0] skip,
                             input logic [31:0] win, input logic [4:0] mask);
        write_reg(lrd_pkg::REG_SAMPLES_PER_BLOCK, {16'd0, spb});
        write_reg(lrd_pkg::REG_SKIP_SAMPLES, skip);
        write_reg(lrd_pkg::REG_WINDOW_SAMPLES, win);
        write_reg(lrd_pkg::REG_CHANNEL_MASK, {27'd0, mask});
        cfg_we   <= 1'b0;
        spb_now  = spb;
        skip_now = skip;
        win_now  = win;
    endtask

    // Drop tvalid and wait until every predicted word has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [23:0] extremes[5];
        logic [15:0] spb;
        logic [31:0] skip;
        logic [31:0] win;
        logic [4:0]  mask;
        int          phase_start;
        t_end_kind   ending;

        extremes = '{24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 24'h000001};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-sample blocks, full mask, every word at a value extreme
        set_idle(IDLE_NONE);
        configure(16'd1, 32'd0, 32'hFFFF_FFFF, 5'h1F);
        for (int k = 0; k < HDR_BYTES; k++) send_byte((k % 2) ? 8'hFF : 8'h00);
        foreach (extremes[k]) begin
            send_byte(extremes[k][7:0]);
            send_byte(extremes[k][15:8]);
            send_byte(extremes[k][23:16]);
        end
        send_unit();
        settle();

        // Random phases: windows that end too far ahead ever to close, varied block size and mask
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_idle(t_idle_mode'(ph % 4));
            if (ph == 4)      spb = 16'hFFFF;
            else if (ph == 7) spb = 16'h0000;   // 65536 samples to a block
            else              spb = blk_fill + 16'($urandom_range(1, 4));
            if (ph == 2 || ph == 5) skip = 32'hFFFF_FFFF;
            else                    skip = $urandom_range(0, smp_sent[31:0] + 32'd3);
            if (ph == 2)                     win = 32'd0;
            else if (ph == 5 || ph % 3 == 0) win = 32'hFFFF_FFFF;
            else                             win = $urandom_range(32'h8000_0000, 32'hFFFF_FFFE);
            if (ph == 3)      mask = 5'h00;
            else if (ph == 6) mask = 5'h1F;
            else              mask = 5'($urandom_range(0, 31));
            configure(spb, skip, win, mask);
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else                           send_unit();
            end
            settle();
        end

        // Close the window just ahead, then feed bytes that must be ignored
        set_idle(t_idle_mode'($urandom_range(0, 3)));
        ending = t_end_kind'($urandom_range(0, 2));
        spb    = blk_fill + 16'($urandom_range(1, 3));
        skip   = smp_sent[31:0] + 32'($urandom_range(0, 2));
        win    = (ending == END_EMPTY_WINDOW) ? 32'd0 : 32'($urandom_range(1, 4));
        mask   = (ending == END_NO_CHANNELS) ? 5'h00 : 5'($urandom_range(1, 31));
        configure(spb, skip, win, mask);
        while (!stream_ended) send_unit();
        repeat (TAIL_BYTES) send_byte(8'($urandom_range(0, 255)));
        settle();

        if (mismatches == 0) begin
            $display("logger_record_deframer_test: done, clean");
        end else begin
            $display("logger_record_deframer_test: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
design/lrd_pkg.sv
design/lrd_frame.sv
design/lrd_emit.sv
design/logger_record_deframer.sv
verif/logger_record_deframer_checker.sv
verif/logger_record_deframer_test.sv
